@@ rtl/assert_macros.svh @@
// assert_macros.svh: shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csfd_pkg.sv @@
// ----------------------------------------------------------------------------
// csfd_pkg
// Constants and helpers for the checksum frame resync deframer.
// ----------------------------------------------------------------------------
package csfd_pkg;

  localparam int FRAME_LEN = 300;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int PTR_W     = $clog2(FRAME_LEN);

  localparam logic [CNT_W-1:0] LEN_C      = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] KEEP_SLIDE = CNT_W'(FRAME_LEN - 4);
  localparam logic [CNT_W-1:0] TYPE_IDX   = CNT_W'(4);

  localparam logic [31:0] HDR_WORD = 32'h55AA_EB90;

  localparam logic [1:0] REG_TYPE_A = 2'd0;
  localparam logic [1:0] REG_TYPE_B = 2'd1;
  localparam logic [1:0] REG_TYPE_C = 2'd2;

  // Ring address: (a + b) mod FRAME_LEN, both operands below FRAME_LEN.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(FRAME_LEN)) s = s - (CNT_W+1)'(FRAME_LEN);
    return s[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/csfd_ram.sv @@
// ----------------------------------------------------------------------------
// csfd_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module csfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/checksum_frame_resync_deframer.sv @@
// A byte is taken while in_stall is low; one that completes a frame starts a
// check pass through the frame store's read port. A good frame then sends its
// words, each gathered from the store byte by byte and then transferred; the
// next word is read only once the previous one is taken. A bad frame rescans
// the store. in_stall is high throughout. Reset (rst_n low, synchronous)
// empties the store, clears both counters and loads type codes 2, 1, 3.
module checksum_frame_resync_deframer
  import csfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_frame_word,
  output logic [3:0]  out_word_bytes,
  output logic        out_last_word,
  output logic [7:0]  out_frame_type,
  output logic [31:0] out_dropped_total,
  output logic [31:0] out_corrupt_total,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0]       state_r;
  logic [PTR_W-1:0] head_r;
  logic [CNT_W-1:0] fill_r, idx_r, didx_r;
  logic             synced_r, dv_r, word_done_r;
  logic [31:0]      win_r, sw_r;
  logic [7:0]       sum_r, type_r;
  logic [31:0]      dropped_r, corrupt_r;
  logic [7:0]       code_a_r, code_b_r, code_c_r;
  logic [63:0]      word_r;
  logic [3:0]       nbytes_r;
  logic             last_r;

  logic             in_xfer, out_xfer, rd_en;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] fill_inc;
  logic [31:0]      win_nxt, sw_nxt;
  logic             type_ok, frame_good;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign fill_inc = fill_r + CNT_W'(1);
  assign win_nxt  = {win_r[23:0], in_rx_byte};
  assign sw_nxt   = {sw_r[23:0], rd_data};
  assign type_ok  = (type_r == code_a_r) || (type_r == code_b_r) || (type_r == code_c_r);
  assign frame_good = (sum_r == rd_data) && type_ok;

  always_comb begin
    rd_en = 1'b0;
    unique case (state_r)
      S_CHECK, S_SCAN: rd_en = (idx_r < LEN_C);
      S_EMIT:          rd_en = !word_done_r && (idx_r < LEN_C);
      default:         rd_en = 1'b0;
    endcase
  end

  csfd_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_store (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (ring_add(head_r, fill_r)),
    .wdata (in_rx_byte),
    .re    (rd_en),
    .raddr (ring_add(head_r, idx_r)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_a_r <= 8'd2;
      code_b_r <= 8'd1;
      code_c_r <= 8'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TYPE_A: code_a_r <= cfg_wdata;
        REG_TYPE_B: code_b_r <= cfg_wdata;
        REG_TYPE_C: code_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      didx_r      <= '0;
      synced_r    <= 1'b0;
      dv_r        <= 1'b0;
      word_done_r <= 1'b0;
      win_r       <= '0;
      sw_r        <= '0;
      dropped_r   <= '0;
      corrupt_r   <= '0;
      sum_r       <= '0;
      type_r      <= '0;
      word_r      <= '0;
      nbytes_r    <= '0;
      last_r      <= 1'b0;
    end else begin
      dv_r   <= rd_en;
      didx_r <= idx_r;
      if (rd_en) idx_r <= idx_r + CNT_W'(1);
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            win_r <= win_nxt;
            if (synced_r) begin
              fill_r <= fill_inc;
              if (fill_inc == LEN_C) begin
                state_r <= S_CHECK;
                idx_r   <= '0;
                sum_r   <= '0;
              end
            end else begin
              if (fill_inc == CNT_W'(5)) begin
                head_r    <= ring_add(head_r, CNT_W'(1));
                fill_r    <= CNT_W'(4);
                dropped_r <= dropped_r + 32'd1;
              end else begin
                fill_r <= fill_inc;
              end
              synced_r <= (fill_inc >= CNT_W'(4)) && (win_nxt == HDR_WORD);
            end
          end
        end
        S_CHECK: begin
          if (dv_r) begin
            if (didx_r == TYPE_IDX) type_r <= rd_data;
            if (didx_r != LAST_IDX) begin
              sum_r <= sum_r + rd_data;
            end else if (frame_good) begin
              state_r     <= S_EMIT;
              idx_r       <= '0;
              word_r      <= '0;
              word_done_r <= 1'b0;
            end else begin
              state_r   <= S_SCAN;
              corrupt_r <= corrupt_r + 32'd1;
              idx_r     <= CNT_W'(1);
              sw_r      <= '0;
            end
          end
        end
        S_EMIT: begin
          if (rd_en && (idx_r[2:0] == 3'd7 || idx_r == LAST_IDX)) word_done_r <= 1'b1;
          if (dv_r) begin
            word_r[8*didx_r[2:0] +: 8] <= rd_data;
            if (didx_r[2:0] == 3'd7 || didx_r == LAST_IDX) begin
              state_r  <= S_OUT;
              nbytes_r <= {1'b0, didx_r[2:0]} + 4'd1;
              last_r   <= (didx_r == LAST_IDX);
            end
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            word_r      <= '0;
            word_done_r <= 1'b0;
            if (last_r) begin
              state_r  <= S_IDLE;
              fill_r   <= '0;
              synced_r <= 1'b0;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (dv_r) begin
            sw_r <= sw_nxt;
            if (didx_r >= CNT_W'(4) && sw_nxt == HDR_WORD) begin
              state_r   <= S_IDLE;
              head_r    <= ring_add(head_r, didx_r - CNT_W'(3));
              fill_r    <= LEN_C - (didx_r - CNT_W'(3));
              dropped_r <= dropped_r + 32'(didx_r - CNT_W'(3));
              synced_r  <= 1'b1;
            end else if (didx_r == LAST_IDX) begin
              state_r   <= S_IDLE;
              head_r    <= ring_add(head_r, KEEP_SLIDE);
              fill_r    <= CNT_W'(4);
              dropped_r <= dropped_r + 32'(KEEP_SLIDE);
              synced_r  <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = (state_r == S_OUT);
  assign out_frame_word    = word_r;
  assign out_word_bytes    = nbytes_r;
  assign out_last_word     = last_r;
  assign out_frame_type    = type_r;
  assign out_dropped_total = dropped_r;
  assign out_corrupt_total = corrupt_r;

endmodule

@@ rtl/csfd_checker.sv @@
// ----------------------------------------------------------------------------
// csfd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_frame_word,
  input logic [3:0]  out_word_bytes,
  input logic        out_last_word,
  input logic [31:0] out_corrupt_total
);

  `CSFD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_frame_word), "held word changed")
  `CSFD_ASSERT_NOW(a_busy, out_valid, in_stall, "input open while a word is pending")
  `CSFD_ASSERT_NOW(a_full, out_valid && !out_last_word, out_word_bytes == 4'd8, "short inner word")
  `CSFD_ASSERT_NOW(a_nb, out_valid, out_word_bytes != 4'd0 && out_word_bytes <= 4'd8, "bad byte count")
  `CSFD_ASSERT_NEXT(a_cnt, out_valid && !out_last_word, $stable(out_corrupt_total), "count moved in frame")

endmodule

bind checksum_frame_resync_deframer csfd_checker u_csfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_word    (out_frame_word),
  .out_word_bytes    (out_word_bytes),
  .out_last_word     (out_last_word),
  .out_corrupt_total (out_corrupt_total)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for checksum_frame_resync_deframer: drives received
// bytes (noise, partial headers, a rejected frame that resyncs onto a good
// one) with random gaps and output stalls, predicts every frame word in a
// local model and compares all output fields in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csfd_pkg::*;

  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam int         IDLE_LIMIT = 20000;
  localparam int         SETTLE     = 2 * FRAME_LEN + 100;

  typedef enum int {K_BYTE, K_BAD_SUM, K_BAD_TYPE} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    int         sel;
    int         hp;
  } stim_row_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nb;
    logic        last;
    logic [7:0]  ftype;
    logic [31:0] dropped;
    logic [31:0] corrupt;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_frame_word;
  logic [3:0]  out_word_bytes;
  logic        out_last_word;
  logic [7:0]  out_frame_type;
  logic [31:0] out_dropped_total;
  logic [31:0] out_corrupt_total;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  logic [7:0]  store_q[$];
  logic [31:0] dropped_cnt;
  logic [31:0] corrupt_cnt;
  logic [7:0]  type_code[3];
  frame_word_t exp_q[$];

  int        err_cnt;
  int        idle_cycles;
  bit        no_idle;
  stim_row_t rnd_row;

  checksum_frame_resync_deframer dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic bit hdr_at(int p);
    if (p + 4 > store_q.size()) return 1'b0;
    return store_q[p] == HDR_WORD[31:24] && store_q[p+1] == HDR_WORD[23:16] &&
           store_q[p+2] == HDR_WORD[15:8] && store_q[p+3] == HDR_WORD[7:0];
  endfunction

  function automatic void shed_front(int n);
    if (n > store_q.size()) n = store_q.size();
    dropped_cnt += n;
    repeat (n) void'(store_q.pop_front());
  endfunction

  function automatic bit frame_ok();
    logic [7:0] sum;
    logic [7:0] t;
    sum = '0;
    t = store_q[4];
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += store_q[i];
    if (sum != store_q[FRAME_LEN-1]) return 1'b0;
    return t == type_code[0] || t == type_code[1] || t == type_code[2];
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    frame_word_t w[$];
    frame_word_t fw;
    int hpos;
    int nxt;
    int nb;
    bit found;
    if (store_q.size() < FRAME_LEN) store_q.push_back(b);
    else dropped_cnt += 1;
    while (store_q.size() >= 4) begin
      hpos = 0;
      while (hpos + 4 <= store_q.size() && !hdr_at(hpos)) hpos++;
      if (hpos + 4 > store_q.size()) begin
        if (store_q.size() > 4) shed_front(store_q.size() - 4);
        break;
      end
      if (hpos > 0) begin
        shed_front(hpos);
        continue;
      end
      if (store_q.size() < FRAME_LEN) break;
      if (frame_ok()) begin
        for (int base = 0; base < FRAME_LEN; base += 8) begin
          nb = (FRAME_LEN - base > 8) ? 8 : FRAME_LEN - base;
          fw = '0;
          for (int j = 0; j < nb; j++) fw.word[8*j +: 8] = store_q[base+j];
          fw.nb = 4'(nb);
          fw.last = (base + 8 >= FRAME_LEN);
          fw.ftype = store_q[4];
          w.push_back(fw);
        end
        store_q.delete();
        continue;
      end
      corrupt_cnt += 1;
      found = 1'b0;
      for (nxt = 1; nxt + 3 < store_q.size(); nxt++) begin
        if (hdr_at(nxt)) begin
          shed_front(nxt);
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        if (store_q.size() > 4) shed_front(store_q.size() - 4);
        else store_q.delete();
      end
    end
    foreach (w[k]) begin
      w[k].dropped = dropped_cnt;
      w[k].corrupt = corrupt_cnt;
      exp_q.push_back(w[k]);
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
  endtask

  // Rejected frame with a header at offset hp, then the hp bytes that
  // complete a good frame starting at that header.
  task automatic send_pair(stim_row_t r);
    logic [7:0] f[FRAME_LEN];
    logic [7:0] g[FRAME_LEN];
    logic [7:0] sum;
    logic [7:0] t;
    bit         flat;
    flat = (r.value == 8'h00 || r.value == 8'hFF);
    foreach (f[i]) f[i] = flat ? r.value : 8'($urandom_range(0, 255));
    {f[0], f[1], f[2], f[3]} = HDR_WORD;
    {f[r.hp], f[r.hp+1], f[r.hp+2], f[r.hp+3]} = HDR_WORD;
    f[r.hp+4] = type_code[r.sel % 3];
    t = type_code[r.sel % 3];
    if (r.kind == K_BAD_TYPE)
      do t = 8'($urandom_range(0, 255));
      while (t == type_code[0] || t == type_code[1] || t == type_code[2]);
    f[4] = t;
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += f[i];
    f[FRAME_LEN-1] = (r.kind == K_BAD_TYPE) ? sum : sum ^ 8'h5A;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i < FRAME_LEN - r.hp) g[i] = f[r.hp+i];
      else g[i] = flat ? r.value : 8'($urandom_range(0, 255));
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += g[i];
    g[FRAME_LEN-1] = sum;
    foreach (f[i]) send_byte(f[i]);
    for (int i = FRAME_LEN - r.hp; i < FRAME_LEN; i++) send_byte(g[i]);
  endtask

  task automatic run_row(stim_row_t r);
    if (r.kind == K_BYTE) send_byte(r.value);
    else send_pair(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx != REG_NONE) type_code[idx] = val;
  endtask

  // ---------------- result checker ----------------
  int stall_left;
  always @(posedge clk) begin
    frame_word_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, out_frame_word);
          err_cnt++;
        end else begin
          e = exp_q.pop_front();
          if (out_frame_word !== e.word) begin
            $display("%0t: frame_word expected %h actual %h", $time, e.word, out_frame_word);
            err_cnt++;
          end
          if (out_word_bytes !== e.nb) begin
            $display("%0t: word_bytes expected %0d actual %0d", $time, e.nb, out_word_bytes);
            err_cnt++;
          end
          if (out_last_word !== e.last) begin
            $display("%0t: last_word expected %0d actual %0d", $time, e.last, out_last_word);
            err_cnt++;
          end
          if (out_frame_type !== e.ftype) begin
            $display("%0t: frame_type expected %h actual %h", $time, e.ftype, out_frame_type);
            err_cnt++;
          end
          if (out_dropped_total !== e.dropped) begin
            $display("%0t: dropped_total expected %0d actual %0d", $time, e.dropped,
                     out_dropped_total);
            err_cnt++;
          end
          if (out_corrupt_total !== e.corrupt) begin
            $display("%0t: corrupt_total expected %0d actual %0d", $time, e.corrupt,
                     out_corrupt_total);
            err_cnt++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------- main sequence ----------------
  stim_row_t dir_rows[$] = '{
    '{K_BYTE, 8'h00, 0, 0}, '{K_BYTE, 8'hFF, 0, 0}, '{K_BYTE, 8'h55, 0, 0},
    '{K_BYTE, 8'h55, 0, 0}, '{K_BYTE, 8'hAA, 0, 0}, '{K_BYTE, 8'hEB, 0, 0},
    '{K_BYTE, 8'h91, 0, 0}, '{K_BYTE, 8'h55, 0, 0}, '{K_BYTE, 8'hAA, 0, 0},
    '{K_BYTE, 8'hEB, 0, 0}
  };

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    out_stall   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_TYPE_A;
    cfg_wdata   <= '0;
    dropped_cnt = '0;
    corrupt_cnt = '0;
    type_code   = '{8'd2, 8'd1, 8'd3};
    err_cnt = 0;
    stall_left = 0;
    no_idle = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) run_row(dir_rows[i]);

    wait_drained();
    write_reg(REG_TYPE_A, 8'h00);
    write_reg(REG_TYPE_B, 8'hFF);
    write_reg(REG_TYPE_C, 8'h80);
    write_reg(REG_NONE, 8'h11);

    rnd_row.kind = K_BYTE;
    rnd_row.sel  = 0;
    rnd_row.hp   = 0;
    repeat ($urandom_range(2, 8)) begin
      rnd_row.value = 8'($urandom_range(0, 84));
      run_row(rnd_row);
    end
    rnd_row.kind  = ($urandom_range(0, 1) == 0) ? K_BAD_SUM : K_BAD_TYPE;
    rnd_row.value = 8'($urandom_range(0, 255));
    rnd_row.sel   = $urandom_range(0, 2);
    rnd_row.hp    = $urandom_range(5, 16);
    run_row(rnd_row);

    wait_drained();
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/csfd_pkg.sv
rtl/csfd_ram.sv
rtl/checksum_frame_resync_deframer.sv
rtl/csfd_checker.sv
tb/tb_top.sv
